FILE: hdl/dle_pkg.sv
// Shared types and constants for the location expression evaluator.
// No dependencies; every other file refers to it by scoped names.
package dle_pkg;

  // Sizes
  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned NUM_REGS     = 32;
  localparam int unsigned MAX_EXPR_LEN = 4096;
  localparam int unsigned POS_CAP_INT  = (MAX_EXPR_LEN - 1 > 4095) ? 4095 : MAX_EXPR_LEN - 1;

  // Field types
  typedef logic [2:0]  func_t;
  typedef logic [2:0]  status_t;
  typedef logic [1:0]  kind_t;
  typedef logic [63:0] word_t;
  typedef logic [11:0] pos_t;
  typedef logic [12:0] len_t;
  typedef logic [2:0]  phase_t;

  // Request kinds
  localparam func_t FUNC_BYTE     = 3'd0;
  localparam func_t FUNC_REG_LOAD = 3'd1;
  localparam func_t FUNC_FB_LOAD  = 3'd2;
  localparam func_t FUNC_MEM_RSP  = 3'd3;
  localparam func_t FUNC_EMPTY    = 3'd4;

  // Result status
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_EMPTY       = 3'd1;
  localparam status_t ST_MALFORMED   = 3'd2;
  localparam status_t ST_UNSUPPORTED = 3'd3;
  localparam status_t ST_UNREADABLE  = 3'd4;

  // Location kinds
  localparam kind_t KIND_NONE     = 2'd0;
  localparam kind_t KIND_ADDR     = 2'd1;
  localparam kind_t KIND_REG      = 2'd2;
  localparam kind_t KIND_IMPLICIT = 2'd3;

  // Result type
  localparam logic RT_FINAL   = 1'b0;
  localparam logic RT_MEM_REQ = 1'b1;

  // Opcodes
  localparam logic [7:0] OP_ADDR        = 8'h03;
  localparam logic [7:0] OP_DEREF       = 8'h06;
  localparam logic [7:0] OP_CONST1U     = 8'h08;
  localparam logic [7:0] OP_CONST1S     = 8'h09;
  localparam logic [7:0] OP_PLUS_UCONST = 8'h23;
  localparam logic [7:0] OP_REG0        = 8'h50;
  localparam logic [7:0] OP_REG31       = 8'h6f;
  localparam logic [7:0] OP_BREG0       = 8'h70;
  localparam logic [7:0] OP_BREG31      = 8'h8f;
  localparam logic [7:0] OP_REGX        = 8'h90;
  localparam logic [7:0] OP_FBREG       = 8'h91;
  localparam logic [7:0] OP_PIECE       = 8'h93;
  localparam logic [7:0] OP_IMPLICIT    = 8'h9e;
  localparam logic [7:0] LEB_DATA_MASK  = 8'h7f;

  // Decoder phases
  localparam phase_t PH_OPCODE = 3'd0;
  localparam phase_t PH_FIXED  = 3'd1;
  localparam phase_t PH_CONST1 = 3'd2;
  localparam phase_t PH_ULEB   = 3'd3;
  localparam phase_t PH_SLEB   = 3'd4;
  localparam phase_t PH_DATA   = 3'd5;

  localparam pos_t POS_CAP   = pos_t'(POS_CAP_INT);
  localparam len_t CNT_MAX   = 13'h1fff;

endpackage

FILE: hdl/dle_req_if.sv
// Input channel of the evaluator: valid/ready plus one request.
// Depends on dle_pkg.
interface dle_req_if;
  logic               valid;
  logic               ready;
  dle_pkg::func_t     func;
  logic [7:0]         byte_value;
  logic               is_last;
  logic [4:0]         reg_index;
  dle_pkg::word_t     data_word;
  logic               ok_flag;

  modport source (output valid, func, byte_value, is_last, reg_index, data_word, ok_flag,
                  input ready);
  modport sink   (input valid, func, byte_value, is_last, reg_index, data_word, ok_flag,
                  output ready);
endinterface

FILE: hdl/dle_res_if.sv
// Output channel of the evaluator: valid/ready plus one result or read request.
// Depends on dle_pkg.
interface dle_res_if;
  logic               valid;
  logic               ready;
  logic               result_type;
  dle_pkg::status_t   status;
  dle_pkg::kind_t     location_kind;
  dle_pkg::word_t     loc_value;
  dle_pkg::pos_t      implicit_offset;
  dle_pkg::len_t      implicit_length;

  modport source (output valid, result_type, status, location_kind, loc_value,
                  implicit_offset, implicit_length, input ready);
  modport sink   (input valid, result_type, status, location_kind, loc_value,
                  implicit_offset, implicit_length, output ready);
endinterface

FILE: hdl/dwarf_location_expr_evaluator_top.sv
// Location expression evaluator: input register, combinational decode, result register.
// Depends on dle_pkg, dle_req_if and dle_res_if.
//
//   channel | direction | carries
//   req_i   | in        | expression byte, register/frame base load, memory response
//   res_o   | out       | final location result or memory read request
//
// One request per cycle while the result register is not stalled; a request waits in the
// input register and its result, if any, is loaded into the result register as it leaves.
// The decoder (opcode, LEB128 shift-or and one 64-bit add) is combinational logic.
// A stalled result register holds the input register; req_i.ready then drops.
// Reset clears all control state and the register valid marks; register values
// are undefined until loaded.
module dwarf_location_expr_evaluator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dle_req_if.sink   req_i,
  dle_res_if.source res_o
);

  // Input register
  logic               s1_valid_q;
  dle_pkg::func_t     s1_func_q;
  logic [7:0]         s1_byte_q;
  logic               s1_last_q;
  logic [4:0]         s1_ridx_q;
  dle_pkg::word_t     s1_data_q;
  logic               s1_ok_q;
  logic               s1_fire;

  assign s1_fire     = s1_valid_q && (!res_o.valid || res_o.ready);
  assign req_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_func_q <= req_i.func;
      s1_byte_q <= req_i.byte_value;
      s1_last_q <= req_i.is_last;
      s1_ridx_q <= req_i.reg_index;
      s1_data_q <= req_i.data_word;
      s1_ok_q   <= req_i.ok_flag;
    end
  end

  // Evaluator state
  dle_pkg::word_t     stack_top_q, stack_top_d;
  logic [5:0]         depth_q, depth_d;
  logic               reg_loc_q, reg_loc_d;
  logic [31:0]        reg_num_q, reg_num_d;
  dle_pkg::word_t     fbase_q, fbase_d;
  dle_pkg::word_t     regfile_q [dle_pkg::NUM_REGS];
  logic [dle_pkg::NUM_REGS-1:0] reg_valid_q, reg_valid_d;
  dle_pkg::phase_t    phase_q, phase_d;
  logic [7:0]         pend_op_q, pend_op_d;
  dle_pkg::word_t     accum_q, accum_d;
  logic [6:0]         shift_q, shift_d;
  dle_pkg::len_t      cnt_q, cnt_d;
  dle_pkg::pos_t      pos_q, pos_d;
  logic               finished_q, finished_d;
  logic               await_q, await_d;
  logic               end_seen_q, end_seen_d;
  dle_pkg::pos_t      impl_start_q, impl_start_d;

  // Step outcome
  logic               fin, fin_last, do_req, eval_end, push_en, clr, reg_wr;
  dle_pkg::status_t   fin_st;
  dle_pkg::kind_t     fin_kind;
  dle_pkg::word_t     fin_val;
  dle_pkg::pos_t      fin_off;
  dle_pkg::len_t      fin_len;
  dle_pkg::word_t     push_v;

  function automatic dle_pkg::pos_t pos_next(input dle_pkg::pos_t p);
    return (p >= dle_pkg::POS_CAP) ? dle_pkg::POS_CAP : p + 12'd1;
  endfunction

  // Decode one request against the current state
  always_comb begin
    dle_pkg::word_t acc;
    logic [4:0]     brr;
    dle_pkg::len_t  cnt;

    stack_top_d  = stack_top_q;
    depth_d      = depth_q;
    reg_loc_d    = reg_loc_q;
    reg_num_d    = reg_num_q;
    fbase_d      = fbase_q;
    reg_valid_d  = reg_valid_q;
    phase_d      = phase_q;
    pend_op_d    = pend_op_q;
    accum_d      = accum_q;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    finished_d   = finished_q;
    await_d      = await_q;
    end_seen_d   = end_seen_q;
    impl_start_d = impl_start_q;

    fin      = 1'b0;
    fin_last = s1_last_q;
    fin_st   = dle_pkg::ST_OK;
    fin_kind = dle_pkg::KIND_NONE;
    fin_val  = '0;
    fin_off  = '0;
    fin_len  = '0;
    do_req   = 1'b0;
    eval_end = 1'b0;
    push_en  = 1'b0;
    push_v   = '0;
    clr      = 1'b0;
    reg_wr   = 1'b0;
    acc      = '0;
    brr      = '0;
    cnt      = '0;

    if (s1_fire) begin
      case (s1_func_q)
        dle_pkg::FUNC_BYTE: begin
          if (await_q) begin
            // byte during an outstanding read is dropped
          end else if (finished_q) begin
            clr = s1_last_q;
          end else begin
            pos_d = pos_next(pos_q);
            case (phase_q)
              dle_pkg::PH_OPCODE: begin
                pend_op_d = s1_byte_q;
                accum_d   = '0;
                shift_d   = '0;
                if (s1_byte_q inside {[dle_pkg::OP_REG0:dle_pkg::OP_REG31]}) begin
                  reg_loc_d = 1'b1;
                  reg_num_d = {24'd0, s1_byte_q - dle_pkg::OP_REG0};
                  eval_end  = s1_last_q;
                end else if (s1_byte_q == dle_pkg::OP_PIECE) begin
                  eval_end = 1'b1;
                end else if (s1_byte_q == dle_pkg::OP_DEREF) begin
                  if (depth_q == 6'd0) begin
                    fin    = 1'b1;
                    fin_st = dle_pkg::ST_MALFORMED;
                  end else begin
                    do_req     = 1'b1;
                    await_d    = 1'b1;
                    end_seen_d = s1_last_q;
                  end
                end else begin
                  if (s1_byte_q == dle_pkg::OP_ADDR) begin
                    phase_d = dle_pkg::PH_FIXED;
                  end else if (s1_byte_q inside {dle_pkg::OP_CONST1U, dle_pkg::OP_CONST1S}) begin
                    phase_d = dle_pkg::PH_CONST1;
                  end else if (s1_byte_q inside {dle_pkg::OP_REGX, dle_pkg::OP_PLUS_UCONST,
                                                 dle_pkg::OP_IMPLICIT}) begin
                    phase_d = dle_pkg::PH_ULEB;
                  end else if (s1_byte_q inside {[dle_pkg::OP_BREG0:dle_pkg::OP_BREG31],
                                                 dle_pkg::OP_FBREG}) begin
                    phase_d = dle_pkg::PH_SLEB;
                  end else begin
                    fin    = 1'b1;
                    fin_st = dle_pkg::ST_UNSUPPORTED;
                  end
                  // operand still owed on the last byte
                  if (!fin && s1_last_q) begin
                    fin    = 1'b1;
                    fin_st = dle_pkg::ST_MALFORMED;
                  end
                end
              end

              dle_pkg::PH_FIXED: begin
                acc     = accum_q | ({56'd0, s1_byte_q} << shift_q[5:0]);
                accum_d = acc;
                shift_d = shift_q + 7'd8;
                if (shift_d[6]) begin
                  push_en = 1'b1;
                  push_v  = acc;
                end else if (s1_last_q) begin
                  fin    = 1'b1;
                  fin_st = dle_pkg::ST_MALFORMED;
                end
              end

              dle_pkg::PH_CONST1: begin
                push_en = 1'b1;
                if (pend_op_q == dle_pkg::OP_CONST1S && s1_byte_q[7]) begin
                  push_v = {56'hff_ffff_ffff_ffff, s1_byte_q};
                end else begin
                  push_v = {56'd0, s1_byte_q};
                end
              end

              dle_pkg::PH_ULEB: begin
                acc     = accum_q |
                          ({56'd0, s1_byte_q & dle_pkg::LEB_DATA_MASK} << shift_q[5:0]);
                accum_d = acc;
                if (!s1_byte_q[7]) begin
                  phase_d = dle_pkg::PH_OPCODE;
                  if (pend_op_q == dle_pkg::OP_REGX) begin
                    reg_loc_d = 1'b1;
                    reg_num_d = acc[31:0];
                    eval_end  = s1_last_q;
                  end else if (pend_op_q == dle_pkg::OP_PLUS_UCONST) begin
                    if (depth_q == 6'd0) begin
                      fin    = 1'b1;
                      fin_st = dle_pkg::ST_MALFORMED;
                    end else begin
                      stack_top_d = stack_top_q + acc;
                      eval_end    = s1_last_q;
                    end
                  end else begin
                    // implicit value: data starts after this byte
                    impl_start_d = pos_next(pos_q);
                    cnt_d        = '0;
                    if (acc == '0) begin
                      fin      = 1'b1;
                      fin_kind = dle_pkg::KIND_IMPLICIT;
                      fin_off  = pos_next(pos_q);
                    end else if (s1_last_q) begin
                      fin    = 1'b1;
                      fin_st = dle_pkg::ST_MALFORMED;
                    end else begin
                      phase_d = dle_pkg::PH_DATA;
                    end
                  end
                end else begin
                  shift_d = shift_q + 7'd7;
                  if (shift_d > 7'd63 || s1_last_q) begin
                    fin    = 1'b1;
                    fin_st = dle_pkg::ST_MALFORMED;
                  end
                end
              end

              dle_pkg::PH_SLEB: begin
                acc     = accum_q |
                          ({56'd0, s1_byte_q & dle_pkg::LEB_DATA_MASK} << shift_q[5:0]);
                shift_d = shift_q + 7'd7;
                if (!s1_byte_q[7]) begin
                  // sign fill from the final group
                  if (!shift_d[6] && s1_byte_q[6]) begin
                    acc = acc | (~64'd0 << shift_d[5:0]);
                  end
                  if (pend_op_q == dle_pkg::OP_FBREG) begin
                    push_en = 1'b1;
                    push_v  = fbase_q + acc;
                  end else begin
                    brr = pend_op_q[4:0] - dle_pkg::OP_BREG0[4:0];
                    if ({1'b0, brr} >= 6'(dle_pkg::NUM_REGS) || !reg_valid_q[brr]) begin
                      fin    = 1'b1;
                      fin_st = dle_pkg::ST_UNSUPPORTED;
                    end else begin
                      push_en = 1'b1;
                      push_v  = regfile_q[brr] + acc;
                    end
                  end
                end else if (shift_d > 7'd63 || s1_last_q) begin
                  fin    = 1'b1;
                  fin_st = dle_pkg::ST_MALFORMED;
                end
                accum_d = acc;
              end

              dle_pkg::PH_DATA: begin
                cnt   = (cnt_q < dle_pkg::CNT_MAX) ? cnt_q + 13'd1 : cnt_q;
                cnt_d = cnt;
                if ({51'd0, cnt} == accum_q) begin
                  fin      = 1'b1;
                  fin_kind = dle_pkg::KIND_IMPLICIT;
                  fin_off  = impl_start_q;
                  fin_len  = cnt;
                end else if (s1_last_q) begin
                  fin    = 1'b1;
                  fin_st = dle_pkg::ST_MALFORMED;
                end
              end

              default: begin
                phase_d = dle_pkg::PH_OPCODE;
              end
            endcase
          end
        end

        dle_pkg::FUNC_REG_LOAD: begin
          if ({1'b0, s1_ridx_q} < 6'(dle_pkg::NUM_REGS)) begin
            reg_wr                 = 1'b1;
            reg_valid_d[s1_ridx_q] = s1_ok_q;
          end
        end

        dle_pkg::FUNC_FB_LOAD: begin
          fbase_d = s1_data_q;
        end

        dle_pkg::FUNC_MEM_RSP: begin
          if (await_q) begin
            await_d  = 1'b0;
            fin_last = end_seen_q;
            if (!s1_ok_q) begin
              fin    = 1'b1;
              fin_st = dle_pkg::ST_UNREADABLE;
            end else begin
              stack_top_d = s1_data_q;
              eval_end    = end_seen_q;
            end
          end
        end

        dle_pkg::FUNC_EMPTY: begin
          fin      = 1'b1;
          fin_last = 1'b1;
          fin_st   = dle_pkg::ST_EMPTY;
        end

        default: begin
          // unused request kinds do nothing
        end
      endcase
    end

    // Push onto the stack, then finish the opcode
    if (push_en) begin
      if (depth_q >= 6'(dle_pkg::STACK_DEPTH)) begin
        fin    = 1'b1;
        fin_st = dle_pkg::ST_MALFORMED;
      end else begin
        stack_top_d = push_v;
        depth_d     = depth_q + 6'd1;
        phase_d     = dle_pkg::PH_OPCODE;
        eval_end    = s1_last_q;
      end
    end

    // End of evaluation: register location wins over the stack
    if (eval_end) begin
      fin = 1'b1;
      if (reg_loc_d) begin
        fin_kind = dle_pkg::KIND_REG;
        fin_val  = {32'd0, reg_num_d};
      end else if (depth_d != 6'd0) begin
        fin_kind = dle_pkg::KIND_ADDR;
        fin_val  = stack_top_d;
      end else begin
        fin_st = dle_pkg::ST_MALFORMED;
      end
    end

    if (fin) begin
      if (fin_last) begin
        clr = 1'b1;
      end else begin
        finished_d = 1'b1;
      end
    end

    // Expression state back to its start
    if (clr) begin
      stack_top_d  = '0;
      depth_d      = '0;
      reg_loc_d    = 1'b0;
      reg_num_d    = '0;
      phase_d      = dle_pkg::PH_OPCODE;
      pend_op_d    = '0;
      accum_d      = '0;
      shift_d      = '0;
      cnt_d        = '0;
      pos_d        = '0;
      finished_d   = 1'b0;
      await_d      = 1'b0;
      end_seen_d   = 1'b0;
      impl_start_d = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top_q  <= '0;
      depth_q      <= '0;
      reg_loc_q    <= 1'b0;
      reg_num_q    <= '0;
      fbase_q      <= '0;
      reg_valid_q  <= '0;
      phase_q      <= dle_pkg::PH_OPCODE;
      pend_op_q    <= '0;
      accum_q      <= '0;
      shift_q      <= '0;
      cnt_q        <= '0;
      pos_q        <= '0;
      finished_q   <= 1'b0;
      await_q      <= 1'b0;
      end_seen_q   <= 1'b0;
      impl_start_q <= '0;
    end else begin
      stack_top_q  <= stack_top_d;
      depth_q      <= depth_d;
      reg_loc_q    <= reg_loc_d;
      reg_num_q    <= reg_num_d;
      fbase_q      <= fbase_d;
      reg_valid_q  <= reg_valid_d;
      phase_q      <= phase_d;
      pend_op_q    <= pend_op_d;
      accum_q      <= accum_d;
      shift_q      <= shift_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      finished_q   <= finished_d;
      await_q      <= await_d;
      end_seen_q   <= end_seen_d;
      impl_start_q <= impl_start_d;
    end
  end

  // Register values, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (reg_wr) begin
      regfile_q[s1_ridx_q] <= s1_data_q;
    end
  end

  // Result register
  logic res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_fire && (fin || do_req)) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && (fin || do_req)) begin
      if (do_req) begin
        res_o.result_type     <= dle_pkg::RT_MEM_REQ;
        res_o.status          <= dle_pkg::ST_OK;
        res_o.location_kind   <= dle_pkg::KIND_NONE;
        res_o.loc_value       <= stack_top_q;
        res_o.implicit_offset <= '0;
        res_o.implicit_length <= '0;
      end else begin
        res_o.result_type     <= dle_pkg::RT_FINAL;
        res_o.status          <= fin_st;
        res_o.location_kind   <= fin_kind;
        res_o.loc_value       <= fin_val;
        res_o.implicit_offset <= fin_off;
        res_o.implicit_length <= fin_len;
      end
    end
  end

  assign res_o.valid = res_valid_q;

  // Checks
  a_no_second_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && do_req) |-> !await_q)
    else $error("read request issued while another is outstanding");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 6'(dle_pkg::STACK_DEPTH))
    else $error("stack depth beyond its limit");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (pos_q == '0 && !finished_q && !await_q && depth_q == '0))
    else $error("expression state not cleared at its end");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_valid_q || res_o.ready) |-> req_i.ready)
    else $error("input stalled while result register is free");

endmodule
